// ===== sv/int_token_parser_dup_check_macros.svh =====
// Assertion macros used by the checker file itpdc_checker.sv.
`ifndef INT_TOKEN_PARSER_DUP_CHECK_MACROS_SVH
`define INT_TOKEN_PARSER_DUP_CHECK_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ITPDC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ITPDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/itpdc_pkg.sv =====
package itpdc_pkg;

   localparam int MAX_VALUES_DEF = 64;
   localparam int CHAR_W         = 8;
   localparam int VALUE_W        = 32;
   localparam int STATUS_W       = 3;
   localparam int INDEX_W        = 6;
   localparam int PROD_W         = VALUE_W + 4;

   localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   localparam logic [PROD_W-1:0] LIMIT_POS = 36'h0_7FFF_FFFF;
   localparam logic [PROD_W-1:0] LIMIT_NEG = 36'h0_8000_0000;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_SYNTAX    = 3'd1,
      ST_OVERFLOW  = 3'd2,
      ST_DUPLICATE = 3'd3,
      ST_FULL      = 3'd4,
      ST_ABORTED   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      POS_START = 2'd0,
      POS_SIGN  = 2'd1,
      POS_DIGIT = 2'd2
   } pos_type;

   // lookup probe walking down the cell row
   typedef struct packed {
      logic               active;
      logic               hit;
      logic [VALUE_W-1:0] key;
   } probe_type;

endpackage

// ===== sv/itpdc_if.sv =====
interface itpdc_req_if;
   logic                           valid;
   logic                           ready;
   logic [itpdc_pkg::CHAR_W-1:0]   char_code;
   logic                           token_end;
   logic                           list_end;

   modport source (output valid, char_code, token_end, list_end, input ready);
   modport sink   (input valid, char_code, token_end, list_end, output ready);
endinterface

interface itpdc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [itpdc_pkg::VALUE_W-1:0] value;
   logic [itpdc_pkg::STATUS_W-1:0]      status;
   logic [itpdc_pkg::INDEX_W-1:0]       token_index;
   logic                                list_done;

   modport source (output valid, value, status, token_index, list_done, input ready);
   modport sink   (input valid, value, status, token_index, list_done, output ready);
endinterface

// ===== sv/itpdc_cell.sv =====
module itpdc_cell #(
   parameter int CNT_W = 7
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              shift_en,
   input  logic [itpdc_pkg::VALUE_W-1:0]     shift_in,
   output logic [itpdc_pkg::VALUE_W-1:0]     store_out,
   input  itpdc_pkg::probe_type              probe_in,
   input  logic [CNT_W-1:0]                  rem_in,
   output itpdc_pkg::probe_type              probe_out,
   output logic [CNT_W-1:0]                  rem_out
);

   logic [itpdc_pkg::VALUE_W-1:0] store_ff;
   itpdc_pkg::probe_type          probe_ff, probe_in_c;
   logic [CNT_W-1:0]              rem_ff, rem_in_c;
   logic                          live;

   // only cells still covered by the remaining count hold written values
   always_comb begin
      live            = (rem_in != '0);
      probe_in_c      = probe_in;
      probe_in_c.hit  = probe_in.hit | (live & (store_ff == probe_in.key));
      rem_in_c        = live ? rem_in - CNT_W'(1) : rem_in;
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         store_ff <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in_c;
      end
      rem_ff <= rem_in_c;
   end

   assign store_out = store_ff;
   assign probe_out = probe_ff;
   assign rem_out   = rem_ff;

endmodule

// ===== sv/itpdc_chain.sv =====
module itpdc_chain #(
   parameter int MAX_VALUES = itpdc_pkg::MAX_VALUES_DEF,
   parameter int CNT_W      = $clog2(MAX_VALUES + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          insert_en,
   input  logic [itpdc_pkg::VALUE_W-1:0] insert_key,
   input  itpdc_pkg::probe_type          probe_head,
   input  logic [CNT_W-1:0]              count_head,
   output itpdc_pkg::probe_type          probe_tail
);

   itpdc_pkg::probe_type          probe_bus [0:MAX_VALUES];
   logic [CNT_W-1:0]              rem_bus   [0:MAX_VALUES];
   logic [itpdc_pkg::VALUE_W-1:0] store_bus [0:MAX_VALUES];

   assign probe_bus[0] = probe_head;
   assign rem_bus[0]   = count_head;
   assign store_bus[0] = insert_key;

   // newest value sits in cell 0; an insert pushes the row down by one
   for (genvar g = 0; g < MAX_VALUES; g++) begin : g_cell
      itpdc_cell #(.CNT_W(CNT_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (insert_en),
         .shift_in  (store_bus[g]),
         .store_out (store_bus[g+1]),
         .probe_in  (probe_bus[g]),
         .rem_in    (rem_bus[g]),
         .probe_out (probe_bus[g+1]),
         .rem_out   (rem_bus[g+1])
      );
   end

   assign probe_tail = probe_bus[MAX_VALUES];

endmodule

// ===== sv/int_token_parser_dup_check.sv =====
// Signed decimal token parser with duplicate check.
// req_chan (valid/ready): one ASCII character per item, token_end on the last
// character of a token, list_end together with token_end on the last token.
// rsp_chan (valid/ready): one item per token: value, status, token_index,
// list_done. value is 0 unless status is ok.
// Characters that do not end a token are taken back to back while ready is high.
// A token end that is already an error (syntax, overflow, aborted) gives its
// result in the cycle after acceptance. A well-formed token walks a probe down the
// row of MAX_VALUES cells, one cell per cycle; its result passes prep_ff,
// launch_ff, the cells and the output register, and no character is taken
// meanwhile. The probe visits each stored value once.
// Reset clears the parser, the stored count, the abort flag and the token
// index; stored values themselves are not cleared, the count masks them.
// Results sit in an output register; while the receiver stalls it holds,
// and req_chan.ready drops as soon as a finished item is waiting and
// not being taken.
module int_token_parser_dup_check #(
   parameter int MAX_VALUES = itpdc_pkg::MAX_VALUES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   itpdc_req_if.sink   req_chan,
   itpdc_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(MAX_VALUES + 1);
   localparam int VW    = itpdc_pkg::VALUE_W;
   localparam int PW    = itpdc_pkg::PROD_W;

   typedef enum logic [1:0] {
      S_PARSE  = 2'b01,
      S_SEARCH = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // per-token parse state
   logic [VW-1:0]      mag_ff, mag_in;
   logic               neg_ff, neg_in;
   itpdc_pkg::pos_type pos_ff, pos_in;
   logic               bad_ff, bad_in;
   logic               ovf_ff, ovf_in;

   // per-list state
   logic [CNT_W-1:0]                 count_ff;
   logic                             aborted_ff;
   logic [itpdc_pkg::INDEX_W-1:0]    idx_ff;
   logic                             last_ff;

   // lookup launch pipeline: magnitude latch, then signed key
   logic          prep_ff, launch_ff;
   logic [VW-1:0] kmag_ff, key_ff;
   logic          kneg_ff;

   // output register
   logic                            rsp_valid_ff;
   logic [VW-1:0]                   rsp_value_ff;
   itpdc_pkg::status_type           rsp_status_ff;
   logic [itpdc_pkg::INDEX_W-1:0]   rsp_index_ff;
   logic                            rsp_done_ff;

   logic                  req_take, tok_take;
   logic                  is_digit, is_sign;
   logic [3:0]            digit;
   logic [PW-1:0]         mag_wide, prod, limit;
   logic                  syntax_err;

   logic                  fin_en, fin_last, insert_en;
   itpdc_pkg::status_type fin_status;
   logic [VW-1:0]         fin_value;

   itpdc_pkg::probe_type  probe_head, probe_tail;

   assign req_chan.ready = (state_ff == S_PARSE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign tok_take       = req_take && req_chan.token_end;

   // character decode and magnitude * 10 + digit as shift-add
   always_comb begin
      is_digit = (req_chan.char_code >= itpdc_pkg::CHAR_0) &&
                 (req_chan.char_code <= itpdc_pkg::CHAR_9);
      is_sign  = (req_chan.char_code == itpdc_pkg::CHAR_PLUS) ||
                 (req_chan.char_code == itpdc_pkg::CHAR_MINUS);
      digit    = 4'(req_chan.char_code - itpdc_pkg::CHAR_0);
      mag_wide = PW'(mag_ff);
      prod     = (mag_wide << 3) + (mag_wide << 1) + PW'(digit);
      limit    = neg_ff ? itpdc_pkg::LIMIT_NEG : itpdc_pkg::LIMIT_POS;

      mag_in = mag_ff;
      neg_in = neg_ff;
      pos_in = pos_ff;
      bad_in = bad_ff;
      ovf_in = ovf_ff;
      if (is_digit) begin
         pos_in = itpdc_pkg::POS_DIGIT;
         if (!ovf_ff) begin
            if (prod > limit) begin
               ovf_in = 1'b1;        // sticky; magnitude frozen from here on
            end else begin
               mag_in = prod[VW-1:0];
            end
         end
      end else if (is_sign && (pos_ff == itpdc_pkg::POS_START)) begin
         neg_in = (req_chan.char_code == itpdc_pkg::CHAR_MINUS);
         pos_in = itpdc_pkg::POS_SIGN;
      end else begin
         bad_in = 1'b1;
      end
      syntax_err = bad_in || (pos_in != itpdc_pkg::POS_DIGIT);
   end

   // token completion: either straight from the parser or from the cell row
   always_comb begin
      fin_en     = 1'b0;
      fin_last   = last_ff;
      fin_status = itpdc_pkg::ST_OK;
      fin_value  = '0;
      insert_en  = 1'b0;
      state_in   = state_ff;
      case (state_ff)
         S_PARSE: begin
            if (tok_take) begin
               fin_last = req_chan.list_end;
               if (aborted_ff) begin
                  fin_en     = 1'b1;
                  fin_status = itpdc_pkg::ST_ABORTED;
               end else if (syntax_err) begin
                  fin_en     = 1'b1;
                  fin_status = itpdc_pkg::ST_SYNTAX;
               end else if (ovf_in) begin
                  fin_en     = 1'b1;
                  fin_status = itpdc_pkg::ST_OVERFLOW;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            if (probe_tail.active) begin
               fin_en   = 1'b1;
               state_in = S_PARSE;
               if (probe_tail.hit) begin
                  fin_status = itpdc_pkg::ST_DUPLICATE;
               end else if (count_ff == CNT_W'(MAX_VALUES)) begin
                  fin_status = itpdc_pkg::ST_FULL;
               end else begin
                  fin_status = itpdc_pkg::ST_OK;
                  fin_value  = key_ff;
                  insert_en  = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_PARSE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_PARSE;
      end else begin
         state_ff <= state_in;
      end
   end

   // parser registers, cleared at every token end
   always_ff @(posedge clock) begin
      if (reset || tok_take) begin
         mag_ff <= '0;
         neg_ff <= 1'b0;
         pos_ff <= itpdc_pkg::POS_START;
         bad_ff <= 1'b0;
         ovf_ff <= 1'b0;
      end else if (req_take) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
         pos_ff <= pos_in;
         bad_ff <= bad_in;
         ovf_ff <= ovf_in;
      end
   end

   // launch of a lookup: latch magnitude, apply sign in the following cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff   <= 1'b0;
         launch_ff <= 1'b0;
      end else begin
         prep_ff   <= (state_ff == S_PARSE) && (state_in == S_SEARCH);
         launch_ff <= prep_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (tok_take) begin
         kmag_ff <= mag_in;
         kneg_ff <= neg_in;
         last_ff <= req_chan.list_end;
      end
      if (prep_ff) begin
         key_ff <= kneg_ff ? (VW'(0) - kmag_ff) : kmag_ff;
      end
   end

   // per-list bookkeeping; list end wipes count, abort flag and index
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         aborted_ff <= 1'b0;
         idx_ff     <= '0;
      end else if (fin_en) begin
         if (fin_last) begin
            count_ff   <= '0;
            aborted_ff <= 1'b0;
            idx_ff     <= '0;
         end else begin
            count_ff   <= insert_en ? count_ff + CNT_W'(1) : count_ff;
            aborted_ff <= aborted_ff | (fin_status != itpdc_pkg::ST_OK);
            idx_ff     <= idx_ff + itpdc_pkg::INDEX_W'(1);
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_en) begin
         rsp_value_ff  <= fin_value;
         rsp_status_ff <= fin_status;
         rsp_index_ff  <= idx_ff;
         rsp_done_ff   <= fin_last;
      end
   end

   // probe enters cell 0 alongside the number of written cells to check
   always_comb begin
      probe_head.active = launch_ff;
      probe_head.hit    = 1'b0;
      probe_head.key    = key_ff;
   end

   itpdc_chain #(
      .MAX_VALUES (MAX_VALUES),
      .CNT_W      (CNT_W)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .insert_en  (insert_en),
      .insert_key (key_ff),
      .probe_head (probe_head),
      .count_head (count_ff),
      .probe_tail (probe_tail)
   );

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.value       = $signed(rsp_value_ff);
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.token_index = rsp_index_ff;
   assign rsp_chan.list_done   = rsp_done_ff;

endmodule

// ===== sv/itpdc_checker.sv =====
`include "int_token_parser_dup_check_macros.svh"

module itpdc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 req_token_end,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [itpdc_pkg::VALUE_W-1:0] rsp_value,
   input logic [itpdc_pkg::STATUS_W-1:0]       rsp_status
);

   logic req_mid, rsp_stall, rsp_err;

   assign req_mid   = req_valid && req_ready && !req_token_end;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_err   = rsp_valid && (rsp_status != itpdc_pkg::ST_OK);

   // a character that ends no token produces nothing
   `ITPDC_ASSERT_NEXT(a_no_rsp_mid_token, clock, reset, req_mid, !rsp_valid)

   // refused tokens carry a zero value
   `ITPDC_ASSERT_NOW(a_err_value_zero, clock, reset, rsp_err, rsp_value == '0)

   `ITPDC_ASSERT_NOW(a_status_legal, clock, reset, rsp_valid, rsp_status <= itpdc_pkg::ST_ABORTED)

   // a stalled result blocks the input side
   `ITPDC_ASSERT_NOW(a_stall_blocks_req, clock, reset, rsp_stall, !req_ready)

   `ITPDC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall,
                      rsp_valid && $stable(rsp_value) && $stable(rsp_status))

endmodule

bind int_token_parser_dup_check itpdc_checker u_itpdc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_token_end (req_chan.token_end),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_value     (rsp_chan.value),
   .rsp_status    (rsp_chan.status)
);

// ===== tb/int_token_parser_dup_check_checker.sv =====
module int_token_parser_dup_check_checker #(
   parameter int MAX_VALUES = itpdc_pkg::MAX_VALUES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [itpdc_pkg::CHAR_W-1:0]         req_char_code,
   input  logic                                 req_token_end,
   input  logic                                 req_list_end,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [itpdc_pkg::VALUE_W-1:0] rsp_value,
   input  logic [itpdc_pkg::STATUS_W-1:0]       rsp_status,
   input  logic [itpdc_pkg::INDEX_W-1:0]        rsp_token_index,
   input  logic                                 rsp_list_done,
   output int                                   fail_count,
   output int                                   tokens_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VW = itpdc_pkg::VALUE_W;
   localparam int IW = itpdc_pkg::INDEX_W;
   localparam int PW = itpdc_pkg::PROD_W;
   localparam int CW = itpdc_pkg::CHAR_W;

   typedef struct packed {
      logic [VW-1:0]         value;
      itpdc_pkg::status_type status;
      logic [IW-1:0]         token_index;
      logic                  list_done;
   } token_result_type;

   token_result_type token_results_due[$];

   // parser state of the token in flight
   logic [VW-1:0]      magnitude;
   logic               negative;
   itpdc_pkg::pos_type char_pos;
   logic               bad_syntax;
   logic               overflowed;
   // per-list state
   logic [VW-1:0]      accepted_values [MAX_VALUES];
   int                 accepted_count;
   logic               list_aborted;
   logic [IW-1:0]      token_index;

   task automatic clear_token();
      magnitude  = '0;
      negative   = 1'b0;
      char_pos   = itpdc_pkg::POS_START;
      bad_syntax = 1'b0;
      overflowed = 1'b0;
   endtask

   task automatic parse_char(input logic [CW-1:0] c, input logic tok_end,
                             input logic lst_end);
      logic [PW-1:0]         grown;
      logic [PW-1:0]         limit;
      logic [VW-1:0]         signed_val;
      logic                  seen;
      itpdc_pkg::status_type st;
      token_result_type      res;
      if (c >= itpdc_pkg::CHAR_0 && c <= itpdc_pkg::CHAR_9) begin
         char_pos = itpdc_pkg::POS_DIGIT;
         if (!overflowed) begin
            limit = negative ? itpdc_pkg::LIMIT_NEG : itpdc_pkg::LIMIT_POS;
            grown = PW'(magnitude) * PW'(10) + PW'(c - itpdc_pkg::CHAR_0);
            if (grown > limit) overflowed = 1'b1;
            else magnitude = grown[VW-1:0];
         end
      end else if ((c == itpdc_pkg::CHAR_PLUS || c == itpdc_pkg::CHAR_MINUS) &&
                   char_pos == itpdc_pkg::POS_START) begin
         negative = (c == itpdc_pkg::CHAR_MINUS);
         char_pos = itpdc_pkg::POS_SIGN;
      end else begin
         bad_syntax = 1'b1;
      end
      if (tok_end) begin
         signed_val = '0;
         if (list_aborted) st = itpdc_pkg::ST_ABORTED;
         else if (bad_syntax || char_pos != itpdc_pkg::POS_DIGIT) st = itpdc_pkg::ST_SYNTAX;
         else if (overflowed) st = itpdc_pkg::ST_OVERFLOW;
         else begin
            signed_val = negative ? (VW'(0) - magnitude) : magnitude;
            seen = 1'b0;
            for (int i = 0; i < accepted_count; i++)
               if (accepted_values[i] == signed_val) seen = 1'b1;
            if (seen) st = itpdc_pkg::ST_DUPLICATE;
            else if (accepted_count >= MAX_VALUES) st = itpdc_pkg::ST_FULL;
            else begin
               accepted_values[accepted_count] = signed_val;
               accepted_count++;
               st = itpdc_pkg::ST_OK;
            end
         end
         if (st != itpdc_pkg::ST_OK) begin
            list_aborted = 1'b1;
            signed_val   = '0;
         end
         res.value       = signed_val;
         res.status      = st;
         res.token_index = token_index;
         res.list_done   = lst_end;
         token_results_due.push_back(res);
         token_index++;
         clear_token();
         if (lst_end) begin
            accepted_count = 0;
            list_aborted   = 1'b0;
            token_index    = '0;
         end
      end
   endtask

   always @(posedge clock) begin
      token_result_type due;
      if (reset) begin
         clear_token();
         accepted_count = 0;
         list_aborted   = 1'b0;
         token_index    = '0;
         fail_count     = 0;
         token_results_due.delete();
      end else begin
         // result first: it can never belong to a token accepted at this edge
         if (rsp_valid && rsp_ready) begin
            if (token_results_due.size() == 0) begin
               $error("unexpected result: value %0d status %0d token_index %0d",
                      rsp_value, rsp_status, rsp_token_index);
               fail_count++;
            end else begin
               due = token_results_due.pop_front();
               if (rsp_value !== due.value) begin
                  $error("value: expected %0d, actual %0d", $signed(due.value), rsp_value);
                  fail_count++;
               end
               if (rsp_status !== due.status) begin
                  $error("status: expected %0d, actual %0d", due.status, rsp_status);
                  fail_count++;
               end
               if (rsp_token_index !== due.token_index) begin
                  $error("token_index: expected %0d, actual %0d",
                         due.token_index, rsp_token_index);
                  fail_count++;
               end
               if (rsp_list_done !== due.list_done) begin
                  $error("list_done: expected %0d, actual %0d", due.list_done, rsp_list_done);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            parse_char(req_char_code, req_token_end, req_list_end);
      end
      tokens_pending <= token_results_due.size();
   end

endmodule

// ===== tb/int_token_parser_dup_check_tb.sv =====
module int_token_parser_dup_check_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_VALUES      = itpdc_pkg::MAX_VALUES_DEF;
   localparam int CW              = itpdc_pkg::CHAR_W;
   localparam int RUN_ITEMS       = 750;
   localparam int CYCLE_LIMIT     = 600000;
   // a well-formed token walks the whole cell row before its result
   localparam int DRAIN_CYCLES    = MAX_VALUES + 16;
   // receiver hold-off, counted in its own clock ticks
   localparam int HOLD_START      = 1500;
   localparam int HOLD_OFF_CYCLES = 300;

   typedef enum {SIGN_NONE, SIGN_PLUS, SIGN_MINUS} sign_type;

   typedef enum {
      TK_SMALL,         // small magnitude, duplicates likely
      TK_WIDE,          // anywhere in range
      TK_EDGE,          // range limits, one past them, long zero runs
      TK_LONE_SIGN,     // sign with no digit
      TK_LATE_SIGN,     // sign after a digit or a second sign
      TK_JUNK,          // arbitrary bytes
      TK_OVF_THEN_JUNK  // overflow, then an illegal char: syntax wins
   } token_kind_type;

   logic clock;
   logic reset;

   itpdc_req_if req_chan ();
   itpdc_rsp_if rsp_chan ();

   int fail_count;
   int tokens_pending;
   int items_sent;
   int cycle_count;
   int list_count;
   logic no_gaps;
   logic [CW-1:0] token_chars[$];

   int_token_parser_dup_check #(
      .MAX_VALUES(MAX_VALUES)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   int_token_parser_dup_check_checker #(
      .MAX_VALUES(MAX_VALUES)
   ) token_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_char_code  (req_chan.char_code),
      .req_token_end  (req_chan.token_end),
      .req_list_end   (req_chan.list_end),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_value      (rsp_chan.value),
      .rsp_status     (rsp_chan.status),
      .rsp_token_index(rsp_chan.token_index),
      .rsp_list_done  (rsp_chan.list_done),
      .fail_count     (fail_count),
      .tokens_pending (tokens_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run limit.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // Sender idle gap: mostly none, sometimes short, rarely long.
   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // One item. Driven at the falling edge, accepted at a rising edge with ready.
   // valid stays high into the next item when no gap follows.
   task automatic send_char(input logic [CW-1:0] c, input logic tok_end,
                            input logic lst_end);
      int gap;
      @(negedge clock);
      req_chan.valid     <= 1'b1;
      req_chan.char_code <= c;
      req_chan.token_end <= tok_end;
      req_chan.list_end  <= lst_end;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
   endtask

   task automatic push_number(input sign_type sg, input longint unsigned mag, input int zeros);
      string digits;
      digits = $sformatf("%0d", mag);
      if (sg == SIGN_PLUS) token_chars.push_back(itpdc_pkg::CHAR_PLUS);
      else if (sg == SIGN_MINUS) token_chars.push_back(itpdc_pkg::CHAR_MINUS);
      repeat (zeros) token_chars.push_back(itpdc_pkg::CHAR_0);
      for (int i = 0; i < digits.len(); i++) token_chars.push_back(digits[i]);
   endtask

   // Sends the built token. list_end on inner chars is noise the block ignores.
   task automatic send_token(input logic last);
      logic stray_end;
      for (int i = 0; i < token_chars.size(); i++) begin
         if (i == token_chars.size() - 1) begin
            send_char(token_chars[i], 1'b1, last);
         end else begin
            stray_end = ($urandom_range(0, 9) == 0);
            send_char(token_chars[i], 1'b0, stray_end);
         end
      end
      token_chars.delete();
   endtask

   task automatic make_token(input token_kind_type kind);
      sign_type         sg;
      longint unsigned  mag;
      int               n;
      sg = sign_type'($urandom_range(0, 2));
      case (kind)
         TK_SMALL: begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
            push_number(sg, $urandom_range(0, 60), n);
         end
         TK_WIDE: begin
            mag = $urandom & 32'h7FFF_FFFF;
            if (sg == SIGN_MINUS) mag += $urandom_range(0, 1);
            push_number(sg, mag, 0);
         end
         TK_EDGE: begin
            case ($urandom_range(0, 5))
               0: push_number((sg == SIGN_MINUS) ? SIGN_NONE : sg, 64'd2147483647,
                              $urandom_range(0, 2));
               1: push_number(SIGN_MINUS, 64'd2147483648, $urandom_range(0, 2));
               2: push_number((sg == SIGN_MINUS) ? SIGN_PLUS : sg, 64'd2147483648, 0);
               3: push_number(SIGN_MINUS, 64'd2147483649, 0);
               4: push_number(sg, {$urandom | 32'h1, $urandom}, 0);
               default: push_number(sg, 64'd0, $urandom_range(0, 12));
            endcase
         end
         TK_LONE_SIGN: token_chars.push_back((sg == SIGN_MINUS) ? itpdc_pkg::CHAR_MINUS
                                                                : itpdc_pkg::CHAR_PLUS);
         TK_LATE_SIGN: begin
            if ($urandom_range(0, 2) == 0) begin
               // two signs in a row
               token_chars.push_back(itpdc_pkg::CHAR_PLUS);
               token_chars.push_back(itpdc_pkg::CHAR_MINUS);
               push_number(SIGN_NONE, $urandom_range(0, 99), 0);
            end else begin
               push_number(sg, $urandom_range(0, 999), 0);
               token_chars.push_back($urandom_range(0, 1) ? itpdc_pkg::CHAR_MINUS
                                                          : itpdc_pkg::CHAR_PLUS);
               if ($urandom_range(0, 1)) push_number(SIGN_NONE, $urandom_range(0, 99), 0);
            end
         end
         TK_JUNK: begin
            n = $urandom_range(1, 3);
            repeat (n) token_chars.push_back(CW'($urandom_range(0, 255)));
         end
         default: begin
            push_number(sg, {$urandom | 32'h1, $urandom}, 0);
            case ($urandom_range(0, 3))
               0: token_chars.push_back(itpdc_pkg::CHAR_MINUS);
               1: token_chars.push_back(8'h20);
               2: token_chars.push_back(8'h3A);
               default: token_chars.push_back(8'hFF);
            endcase
         end
      endcase
   endtask

   function automatic token_kind_type pick_kind(input logic clean_list);
      int r;
      r = $urandom_range(0, 99);
      if (clean_list) begin
         if (r < 50) return TK_SMALL;
         if (r < 90) return TK_WIDE;
         return TK_EDGE;
      end
      if (r < 35) return TK_SMALL;
      if (r < 60) return TK_WIDE;
      if (r < 70) return TK_EDGE;
      if (r < 77) return TK_LONE_SIGN;
      if (r < 84) return TK_LATE_SIGN;
      if (r < 93) return TK_JUNK;
      return TK_OVF_THEN_JUNK;
   endfunction

   // Fills the table, then one more token: new (table full) or a repeat
   // (duplicate beats table full). Index wraps past 63 on the tail tokens.
   task automatic send_full_list(input logic repeat_first);
      longint unsigned first_mag;
      longint unsigned mag;
      first_mag = 0;
      for (int i = 0; i < MAX_VALUES; i++) begin
         // one decade per token keeps the values distinct and short
         mag = longint'(i * 10) + $urandom_range(0, 9);
         if (i == 0) first_mag = mag;
         push_number(SIGN_NONE, mag, 0);
         send_token(1'b0);
      end
      push_number(SIGN_PLUS, repeat_first ? first_mag : longint'(MAX_VALUES * 10 + 7), 0);
      send_token(1'b0);
      make_token(TK_SMALL);
      send_token(1'b0);
      make_token(TK_SMALL);
      send_token(1'b1);
   endtask

   // Receiver: random stalls, calm stretches, and one long hold-off that
   // backs the block up until it stops taking characters.
   initial begin
      int ticks;
      int stall_left;
      int calm_left;
      int r;
      ticks      = 0;
      stall_left = 0;
      calm_left  = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         ticks++;
         if (ticks >= HOLD_START && ticks < HOLD_START + HOLD_OFF_CYCLES) begin
            rsp_chan.ready <= 1'b0;
         end else if (calm_left > 0) begin
            calm_left--;
            rsp_chan.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
               calm_left = $urandom_range(50, 150);
               rsp_chan.ready <= 1'b1;
            end else if (r < 30) begin
               stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                        : $urandom_range(0, 2);
               rsp_chan.ready <= 1'b0;
            end else begin
               rsp_chan.ready <= 1'b1;
            end
         end
      end
   end

   // Stimulus and verdict
   initial begin
      int n_tokens;
      logic clean_list;
      items_sent = 0;
      list_count = 0;
      no_gaps    = 1'b0;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.char_code = '0;
      req_chan.token_end = 1'b0;
      req_chan.list_end  = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: ok, lone sign, aborted tail
      send_char("5", 1'b1, 1'b0);
      send_char(itpdc_pkg::CHAR_MINUS, 1'b1, 1'b0);
      send_char("9", 1'b1, 1'b1);
      // list_end without token_end is ignored; "+12" repeats 12
      send_char("1", 1'b0, 1'b1);
      send_char("2", 1'b1, 1'b0);
      send_char(itpdc_pkg::CHAR_PLUS, 1'b0, 1'b0);
      send_char("1", 1'b0, 1'b0);
      send_char("2", 1'b1, 1'b0);
      send_char("3", 1'b1, 1'b1);
      // zero, then minus zero is the same value
      send_char(itpdc_pkg::CHAR_0, 1'b1, 1'b0);
      send_char(itpdc_pkg::CHAR_MINUS, 1'b0, 1'b0);
      send_char(itpdc_pkg::CHAR_0, 1'b1, 1'b1);
      // sign after a digit
      send_char("1", 1'b0, 1'b0);
      send_char(itpdc_pkg::CHAR_PLUS, 1'b1, 1'b0);
      send_char("7", 1'b1, 1'b1);
      // extreme char codes
      send_char(8'hFF, 1'b0, 1'b0);
      send_char(itpdc_pkg::CHAR_0, 1'b1, 1'b1);
      send_char(8'h00, 1'b1, 1'b1);

      // range limits up front, then random lists
      push_number(SIGN_NONE, 64'd2147483647, 0);
      send_token(1'b0);
      push_number(SIGN_MINUS, 64'd2147483648, 0);
      send_token(1'b0);
      push_number(SIGN_NONE, 64'd2147483648, 0);
      send_token(1'b1);

      while (items_sent < RUN_ITEMS) begin
         list_count++;
         no_gaps = ($urandom_range(0, 9) == 0);
         if (list_count == 4) begin
            send_full_list(1'b1);
         end else if (list_count == 12) begin
            send_full_list(1'b0);
         end else begin
            clean_list = ($urandom_range(0, 99) < 60);
            n_tokens = $urandom_range(1, 8);
            for (int t = 0; t < n_tokens; t++) begin
               make_token(pick_kind(clean_list));
               send_token(t == n_tokens - 1);
            end
         end
      end
      @(negedge clock);
      req_chan.valid <= 1'b0;

      // drain, then let the block settle
      do @(posedge clock); while (tokens_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
